// File: hw/rtl/atp_pkg.sv
package atp_pkg;

  localparam int unsigned DivSteps = 16;

  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic [47:0] C1Q32 = 48'd3373259426;
  localparam logic [59:0] KQ32  = 60'd782113545;
  localparam logic [50:0] BaseLoQ47 = 51'd3373259426 << 15;
  localparam logic [50:0] BaseHiQ47 = 51'd10119778278 << 15;
  localparam logic [50:0] RoundHalf = 51'd1 << 33;

  // sideband that rides along the divider and polynomial stages
  typedef struct packed {
    logic               base_hi;  // x < 0: base is 3pi/4
    logic               neg_r;    // quotient negative
    logic               y_neg;    // negate final angle
    logic               special;  // x == 0
    logic signed [15:0] spec_ang;
  } side_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [16:0] den;    // up to 65536 when x and y are both full-scale negative
    logic [15:0] quot;
    logic [15:0] dbits;  // remaining dividend bits, msb first
  } div_t;

endpackage

// File: hw/rtl/atp_div_cell.sv
module atp_div_cell import atp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  div_t  div_i,
  input  side_t side_i,
  output logic  valid_o,
  output div_t  div_o,
  output side_t side_o
);

  logic  valid_q;
  div_t  div_q, div_d;
  side_t side_q;
  logic [16:0] trial;
  logic        ge;

  // one restoring step: bring down a bit, subtract if it fits
  always_comb begin
    trial       = {div_i.rem, div_i.dbits[15]};
    ge          = trial >= div_i.den;
    div_d.den   = div_i.den;
    div_d.rem   = ge ? 16'(trial - div_i.den) : trial[15:0];
    div_d.quot  = {div_i.quot[14:0], ge};
    div_d.dbits = {div_i.dbits[14:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q  <= div_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

// File: hw/rtl/atp_poly.sv
module atp_poly import atp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [15:0]        m_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic signed [15:0] angle_o
);

  logic [4:0]  vld_q;
  side_t       s1_q, s2_q, s3_q, s4_q;
  logic [15:0] m1_q;
  logic [31:0] mm_q;
  logic [47:0] t1a_q, t1b_q, t1c_q;
  logic [29:0] p_q;
  logic [44:0] t2_q;
  logic [47:0] d_q;
  logic signed [15:0] ang_q, ang_d;

  logic [46:0] q_full;
  logic [59:0] kp_full;
  logic [50:0] base, acc;
  logic [15:0] res;

  assign q_full  = 47'(m1_q) * 47'(31'(32'd1 << 30) - 31'(mm_q));
  assign kp_full = KQ32 * 60'(p_q);

  always_comb begin
    base  = s4_q.base_hi ? BaseHiQ47 : BaseLoQ47;
    if (s4_q.neg_r) begin
      acc = base + 51'(d_q);
    end else begin
      acc = (base >= 51'(d_q)) ? base - 51'(d_q) : '0;
    end
    res   = 16'((acc + RoundHalf) >> 34);
    if (s4_q.special) begin
      ang_d = s4_q.spec_ang;
    end else if (s4_q.y_neg) begin
      ang_d = -$signed(res);
    end else begin
      ang_d = $signed(res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // m^2 and pi/4*m
      m1_q  <= m_i;
      mm_q  <= 32'(m_i) * 32'(m_i);
      t1a_q <= 48'(m_i) * C1Q32;
      s1_q  <= side_i;
      // p = m*(1 - m^2) in Q30
      p_q   <= q_full[44:15];
      t1b_q <= t1a_q;
      s2_q  <= s1_q;
      // K*p to Q47
      t2_q  <= kp_full[59:15];
      t1c_q <= t1b_q;
      s3_q  <= s2_q;
      // magnitude of the correction
      d_q   <= (t1c_q >= 48'(t2_q)) ? t1c_q - 48'(t2_q) : '0;
      s4_q  <= s3_q;
      // base +- d, round, sign
      ang_q <= ang_d;
    end
  end

  assign valid_o = vld_q[4];
  assign angle_o = ang_q;

endmodule

// File: hw/rtl/atan2_polynomial_approx_top.sv
// atan2(y, x) stream block. Each input beat carries a signed 16-bit point
// and yields one output beat with the angle in radians, signed Q3.13, in
// [-pi, +pi]. A new beat can enter every cycle unless the output stalls. The
// pipe is one prepare stage, a chain of 16 divider cells that each resolve one
// quotient bit, and five polynomial stages whose last register drives the
// output; the whole pipe holds while the output beat waits on m_axis_tready_i.
module atan2_polynomial_approx_top import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] x_coord, [31:16] y_coord
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] angle
);

  logic en;
  logic signed [15:0] x, y;
  logic [16:0] ay;
  logic signed [17:0] num, den;
  logic [17:0] anum;
  div_t  div_d;
  side_t side_d;

  logic  pv_q;
  div_t  pdiv_q;
  side_t pside_q;

  logic  [DivSteps:0] cv;
  div_t  cd [DivSteps+1];
  side_t cs [DivSteps+1];

  logic signed [15:0] angle;

  // pipe advances unless the output beat is stalled
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign x = s_axis_tdata_i[15:0];
  assign y = s_axis_tdata_i[31:16];

  always_comb begin
    ay  = y[15] ? 17'(-$signed({y[15], y})) : 17'({1'b0, y});
    if (!x[15]) begin
      num = 18'(x) - $signed({1'b0, ay});
      den = 18'(x) + $signed({1'b0, ay});
    end else begin
      num = 18'(x) + $signed({1'b0, ay});
      den = $signed({1'b0, ay}) - 18'(x);
    end
    anum = num[17] ? 18'(-num) : 18'(num);
    // dividend is |num| << 15; quotient fits 16 bits
    div_d.rem   = anum[16:1];
    div_d.den   = den[16:0];
    div_d.quot  = '0;
    div_d.dbits = {anum[0], 15'b0};
    side_d.base_hi  = x[15];
    side_d.neg_r    = num[17];
    side_d.y_neg    = y[15];
    side_d.special  = (x == 16'sd0);
    side_d.spec_ang = (y == 16'sd0) ? 16'sd0 : (y[15] ? -HalfPiQ13 : HalfPiQ13);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdiv_q  <= div_d;
      pside_q <= side_d;
    end
  end

  assign cv[0] = pv_q;
  assign cd[0] = pdiv_q;
  assign cs[0] = pside_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    atp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .div_i   (cd[i]),
      .side_i  (cs[i]),
      .valid_o (cv[i+1]),
      .div_o   (cd[i+1]),
      .side_o  (cs[i+1])
    );
  end

  atp_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cv[DivSteps]),
    .m_i     (cd[DivSteps].quot),
    .side_i  (cs[DivSteps]),
    .valid_o (m_axis_tvalid_o),
    .angle_o (angle)
  );

  assign m_axis_tdata_o = angle;

endmodule

// File: hw/rtl/atan2_polynomial_approx_chk.sv
module atan2_polynomial_approx_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o) <= 16'sd25736 &&
                         $signed(m_axis_tdata_o) >= -16'sd25736))
    else $error("angle outside [-pi, pi]");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

endmodule

bind atan2_polynomial_approx_top atan2_polynomial_approx_chk u_chk (.*);
